// ===== rtl/bgr_pkg.sv =====
// Shared types and constants for the bitmap glyph row renderer.
package bgr_pkg;

  localparam int unsigned FONT_BYTES_DEF    = 32768;
  localparam int unsigned SCREEN_WIDTH_DEF  = 1920;
  localparam int unsigned SCREEN_HEIGHT_DEF = 1080;

  // Width of the linear cell position, which is also the dividend of the divider.
  localparam int unsigned POS_W = 22;

  localparam logic [25:0] FB_BASE = 26'h200_0000;

  localparam logic [5:0] WIDTH_RST  = 6'd8;
  localparam logic [5:0] HEIGHT_RST = 6'd16;
  localparam logic [7:0] BPG_RST    = 8'd16;

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH     = 2'd0,
    REG_GLYPH_HEIGHT    = 2'd1,
    REG_BYTES_PER_GLYPH = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_CELL   = 2'd1,
    MODE_LINEAR = 2'd2
  } mode_t;

endpackage

// ===== rtl/bgr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module bgr_div #(
  parameter int unsigned DW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bgr_pkg::POS_W-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [bgr_pkg::POS_W-1:0] quotient,
  output logic [DW-1:0]            remainder
);

  localparam int unsigned NW = bgr_pkg::POS_W;
  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] count;
  logic            running;
  logic [DW-1:0]   dsr;
  logic [DW:0]     r_shift;
  logic            fits;

  // Shift in the next dividend bit and try one subtraction.
  always_comb begin
    r_shift = {remainder, quotient[NW-1]};
    fits    = r_shift >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else if (start) begin
      running   <= 1'b1;
      done      <= 1'b0;
      count     <= CNTW'(NW);
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (running) begin
      remainder <= fits ? DW'(r_shift - {1'b0, dsr}) : r_shift[DW-1:0];
      quotient  <= {quotient[NW-2:0], fits};
      count     <= count - 1'b1;
      if (count == CNTW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bitmap_glyph_row_renderer_unit.sv =====
// Top level of the bitmap glyph row renderer: font store, sequencer and row output.
//
// Usage: an item is taken at a rising edge with start high and busy low. Mode
// load writes font_byte into the font store, mode cell renders char_code at
// cell_column/cell_row, mode linear renders at linear_position, which is split
// into column and row by the number of cells that fit on one screen line.
// A render emits one result per glyph row, top to bottom: strobe is high for
// one cycle with row_address, row_pixels and last_row. A cell that does not
// fit on the screen gives no result, and neither do loads or mode three.
// Steps: the store address is reduced modulo the store size one bit per
// cycle; linear positions also run the divider in parallel. A load then
// writes its byte and ends. For a render, the address and bounds arithmetic
// follows in states S_CALC1 and S_CALC2, then the store is read one byte per
// cycle. The registered read of the single-port font store sets the row rate.
// Reset restores the default geometry (8 by 16, 16 bytes per glyph) and
// stops any render; the store itself is not cleared and must be written
// before it is read. Results cannot be stalled by the receiver.
module bitmap_glyph_row_renderer_unit #(
  parameter int unsigned FONT_BYTES    = bgr_pkg::FONT_BYTES_DEF,
  parameter int unsigned SCREEN_WIDTH  = bgr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = bgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_column,
  input  logic [10:0] cell_row,
  input  logic [21:0] linear_position,
  input  logic [14:0] font_address,
  input  logic [7:0]  font_byte,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [7:0]  wr_data,
  output logic        strobe,
  output logic [25:0] row_address,
  output logic [31:0] row_pixels,
  output logic        last_row
);

  localparam int unsigned AW = $clog2(FONT_BYTES);
  localparam int unsigned CW = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned PW = bgr_pkg::POS_W;
  localparam logic [AW+1:0] F1 = (AW+2)'(FONT_BYTES);
  localparam logic [AW+1:0] F2 = (AW+2)'(2 * FONT_BYTES);
  localparam logic [25:0] ROW_STRIDE = 26'(SCREEN_WIDTH * 3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CALC1,
    S_CALC2,
    S_STREAM
  } state_t;

  // Configuration registers, kept as written and clamped where used.
  logic [5:0] glyph_width;
  logic [5:0] glyph_height;
  logic [7:0] bytes_per_glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width     <= bgr_pkg::WIDTH_RST;
      glyph_height    <= bgr_pkg::HEIGHT_RST;
      bytes_per_glyph <= bgr_pkg::BPG_RST;
    end else if (wr_en) begin
      case (wr_index)
        bgr_pkg::REG_GLYPH_WIDTH:     glyph_width     <= wr_data[5:0];
        bgr_pkg::REG_GLYPH_HEIGHT:    glyph_height    <= wr_data[5:0];
        bgr_pkg::REG_BYTES_PER_GLYPH: bytes_per_glyph <= wr_data;
        default: ;
      endcase
    end
  end

  // Clamped geometry: zero counts as one and anything above 32 as 32.
  logic [5:0]  w_c;
  logic [5:0]  h_c;
  logic [5:0]  w_m1;
  logic [4:0]  h_m1;
  logic [1:0]  wb_m1;
  logic [31:0] keep;

  always_comb begin
    w_c   = (glyph_width == 6'd0) ? 6'd1 : (glyph_width > 6'd32) ? 6'd32 : glyph_width;
    h_c   = (glyph_height == 6'd0) ? 6'd1 : (glyph_height > 6'd32) ? 6'd32 : glyph_height;
    w_m1  = w_c - 6'd1;
    h_m1  = 5'(h_c - 6'd1);
    // Bytes per row minus one is (width - 1) / 8.
    wb_m1 = 2'(w_m1 >> 3);
    // Only the leftmost width bits of a row are kept; a shift by 32 gives zero.
    keep  = ~(32'hFFFF_FFFF >> w_c);
  end

  // Cells per screen line for every glyph width, fixed at elaboration.
  logic [CW-1:0] cols_tab [32];
  for (genvar gi = 0; gi < 32; gi++) begin : g_cols
    localparam int unsigned COLS = SCREEN_WIDTH / (gi + 1);
    assign cols_tab[gi] = CW'(COLS);
  end

  state_t        state;
  logic [1:0]    mode_q;
  logic [14:0]   src_q;
  logic [7:0]    addend_q;
  logic [7:0]    fbyte_q;
  logic [3:0]    step;
  logic [AW-1:0] acc;
  logic [AW-1:0] ptr;
  logic [PW-1:0] cx;
  logic [PW-1:0] cy;
  logic [27:0]   prod_x;
  logic [27:0]   prod_y;
  logic [25:0]   row_addr;
  logic          issue_on;
  logic [4:0]    issue_row;
  logic [1:0]    issue_slot;
  logic          cap_on;
  logic [4:0]    cap_row;
  logic [1:0]    cap_slot;
  logic [31:0]   bits_acc;
  logic [7:0]    rd_data;

  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [PW-1:0] div_q;
  logic [CW-1:0] div_r;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign div_start = accept && (mode == bgr_pkg::MODE_LINEAR);

  bgr_div #(
    .DW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (linear_position),
    .divisor  (cols_tab[w_m1[4:0]]),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // One step of the store address reduction: the glyph base is built as
  // bytes_per_glyph * char_code, and a load address as itself, one bit of the
  // source at a time, MSB first, staying below the store size throughout.
  logic [AW+1:0] red_t;
  logic [AW-1:0] red_next;

  always_comb begin
    red_t = {1'b0, acc, 1'b0} + (AW+2)'(src_q[14] ? addend_q : 8'd0);
    if (red_t >= F2) begin
      red_next = AW'(red_t - F2);
    end else if (red_t >= F1) begin
      red_next = AW'(red_t - F1);
    end else begin
      red_next = AW'(red_t);
    end
  end

  // Next store pointer, wrapping at the store size.
  logic [AW:0]   ptr_inc;
  logic [AW-1:0] ptr_next;

  always_comb begin
    ptr_inc  = (AW+1)'(ptr) + 1'b1;
    ptr_next = (ptr_inc == (AW+1)'(FONT_BYTES)) ? '0 : ptr_inc[AW-1:0];
  end

  // Bounds check and address of the top row, from the registered products.
  logic        off_screen;
  logic [25:0] addr_top;

  always_comb begin
    off_screen = ((29'(prod_x) + 29'(w_c)) > 29'(SCREEN_WIDTH)) ||
                 ((29'(prod_y) + 29'(h_c)) > 29'(SCREEN_HEIGHT));
    addr_top   = bgr_pkg::FB_BASE + prod_x[25:0] * 26'd3 + prod_y[25:0] * ROW_STRIDE;
  end

  // The byte returning from the store lands in its place in the row.
  logic [31:0] merged;
  assign merged = bits_acc | ({rd_data, 24'd0} >> {cap_slot, 3'b000});

  logic reduce_end;
  logic store_we;
  logic store_re;

  assign reduce_end = (state == S_REDUCE) && (step == 4'd15) &&
                      ((mode_q != bgr_pkg::MODE_LINEAR) || div_done);
  assign store_we   = reduce_end && (mode_q == bgr_pkg::MODE_LOAD);
  assign store_re   = (state == S_STREAM) && issue_on;

  // Font store: one synchronous write or read per cycle. Loads and renders
  // never overlap, so a read never meets a pending write to the same entry.
  logic [7:0] glyph_store [FONT_BYTES];

  always_ff @(posedge clk) begin
    if (store_we) begin
      glyph_store[acc] <= fbyte_q;
    end
    if (store_re) begin
      rd_data <= glyph_store[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      strobe   <= 1'b0;
      issue_on <= 1'b0;
      cap_on   <= 1'b0;
    end else begin
      // A row goes out in the cycle after its last byte returns.
      strobe <= (state == S_STREAM) && cap_on && (cap_slot == wb_m1);
      case (state)
        S_IDLE: begin
          if (accept && (mode inside {bgr_pkg::MODE_LOAD, bgr_pkg::MODE_CELL,
                                      bgr_pkg::MODE_LINEAR})) begin
            state    <= S_REDUCE;
            mode_q   <= mode;
            step     <= 4'd0;
            acc      <= '0;
            fbyte_q  <= font_byte;
            cx       <= PW'(cell_column);
            cy       <= PW'(cell_row);
            if (mode == bgr_pkg::MODE_LOAD) begin
              src_q    <= font_address;
              addend_q <= 8'd1;
            end else begin
              src_q    <= {7'd0, char_code};
              addend_q <= bytes_per_glyph;
            end
          end
        end
        S_REDUCE: begin
          if (step != 4'd15) begin
            acc   <= red_next;
            src_q <= {src_q[13:0], 1'b0};
            step  <= step + 4'd1;
          end else if (reduce_end) begin
            if (mode_q == bgr_pkg::MODE_LOAD) begin
              state <= S_IDLE;
            end else begin
              state <= S_CALC1;
              if (mode_q == bgr_pkg::MODE_LINEAR) begin
                cx <= PW'(div_r);
                cy <= div_q;
              end
            end
          end
        end
        S_CALC1: begin
          prod_x <= 28'(cx) * 28'(w_c);
          prod_y <= 28'(cy) * 28'(h_c);
          state  <= S_CALC2;
        end
        S_CALC2: begin
          if (off_screen) begin
            state <= S_IDLE;
          end else begin
            state      <= S_STREAM;
            row_addr   <= addr_top;
            ptr        <= acc;
            issue_on   <= 1'b1;
            issue_row  <= 5'd0;
            issue_slot <= 2'd0;
            cap_on     <= 1'b0;
            bits_acc   <= '0;
          end
        end
        S_STREAM: begin
          // Read side: one store byte a cycle through the whole glyph. The
          // return side stops by itself once the read side has finished.
          cap_on   <= issue_on;
          cap_row  <= issue_row;
          cap_slot <= issue_slot;
          if (issue_on) begin
            ptr <= ptr_next;
            if (issue_slot == wb_m1) begin
              issue_slot <= 2'd0;
              if (issue_row == h_m1) begin
                issue_on <= 1'b0;
              end else begin
                issue_row <= issue_row + 5'd1;
              end
            end else begin
              issue_slot <= issue_slot + 2'd1;
            end
          end
          // Return side: gather the row and emit it after its last byte.
          if (cap_on) begin
            if (cap_slot == wb_m1) begin
              row_pixels  <= merged & keep;
              row_address <= row_addr;
              last_row    <= (cap_row == h_m1);
              row_addr    <= row_addr + ROW_STRIDE;
              bits_acc    <= '0;
              if (cap_row == h_m1) begin
                state <= S_IDLE;
              end
            end else begin
              bits_acc <= merged;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the bitmap glyph row renderer: stimulus, predictor and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bgr_pkg::*;

  // Mode three is not part of the package's mode list; the block must ignore it.
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam int unsigned SCREEN_W = SCREEN_WIDTH_DEF;
  localparam int unsigned SCREEN_H = SCREEN_HEIGHT_DEF;
  localparam int unsigned STORE_BYTES = FONT_BYTES_DEF;

  // A load and a render that lands off screen end with no strobe to show that
  // they are done, so this many cycles of quiet are allowed before a register
  // write and at the end of the run.
  localparam int QUIET_CYCLES = 64;

  // The longest correct stretch without any accepted item, result or write is a
  // settle pause plus a sender gap plus one render's lead-in; this is many times that.
  localparam int WATCHDOG_CYCLES = 2000;

  // One input item as the block sees it on its ports.
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  code;
    logic [10:0] column;
    logic [10:0] row;
    logic [21:0] position;
    logic [14:0] font_addr;
    logic [7:0]  font_data;
  } glyph_cmd_t;

  // One glyph row as it should appear on the result ports.
  typedef struct {
    logic [25:0] addr;
    logic [31:0] pixels;
    logic        last;
  } glyph_row_t;

  // Keeps a copy of the font store and the geometry registers, turns every
  // accepted item into the glyph rows it must produce, and checks each strobed
  // row against the oldest one still owed.
  class glyph_scoreboard;
    byte unsigned font_mem[STORE_BYTES];
    bit           written[STORE_BYTES];
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  stride_reg;
    glyph_row_t   owed_rows[$];
    int unsigned  errors;
    int unsigned  loads;
    int unsigned  drawn_glyphs;
    int unsigned  silent_items;
    int unsigned  rows_seen;

    function new();
      width_reg  = 32'(WIDTH_RST);
      height_reg = 32'(HEIGHT_RST);
      stride_reg = 32'(BPG_RST);
    endfunction

    // Zero counts as one and anything above 32 as 32.
    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > 32) return 32;
      return v;
    endfunction

    function void set_reg(reg_index_t idx, logic [7:0] val);
      case (idx)
        REG_GLYPH_WIDTH:     width_reg  = 32'(val & 8'h3F);
        REG_GLYPH_HEIGHT:    height_reg = 32'(val & 8'h3F);
        REG_BYTES_PER_GLYPH: stride_reg = 32'(val);
        default: ;
      endcase
    endfunction

    function int unsigned glyph_byte_addr(logic [7:0] code, int unsigned offset);
      return (stride_reg * code + offset) % STORE_BYTES;
    endfunction

    // True when every byte the glyph needs under the current geometry has been loaded.
    function bit glyph_ready(logic [7:0] code);
      int unsigned n;
      n = clamp_dim(height_reg) * ((clamp_dim(width_reg) + 7) / 8);
      for (int unsigned k = 0; k < n; k++) begin
        if (!written[glyph_byte_addr(code, k)]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void predict_glyph(logic [7:0] code, int unsigned cx, int unsigned cy);
      int unsigned w;
      int unsigned h;
      int unsigned wb;
      logic [31:0] keep;
      logic [31:0] bits;
      glyph_row_t  r;
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      wb = (w + 7) / 8;
      if (cx >= SCREEN_W / w || cy >= SCREEN_H / h) begin
        silent_items++;
        return;
      end
      keep = (w >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> w);
      for (int unsigned y = 0; y < h; y++) begin
        bits = '0;
        for (int unsigned i = 0; i < wb; i++) begin
          bits |= 32'(font_mem[glyph_byte_addr(code, y * wb + i)]) << (24 - 8 * i);
        end
        r.addr   = 26'(32'(FB_BASE) + (cx * w + (cy * h + y) * SCREEN_W) * 3);
        r.pixels = bits & keep;
        r.last   = (y + 1 == h);
        owed_rows.push_back(r);
      end
      drawn_glyphs++;
    endfunction

    function void note_item(glyph_cmd_t c);
      int unsigned cols;
      case (c.mode)
        MODE_LOAD: begin
          font_mem[c.font_addr] = c.font_data;
          written[c.font_addr]  = 1'b1;
          loads++;
        end
        MODE_CELL: predict_glyph(c.code, c.column, c.row);
        MODE_LINEAR: begin
          cols = SCREEN_W / clamp_dim(width_reg);
          predict_glyph(c.code, c.position % cols, c.position / cols);
        end
        default: silent_items++;
      endcase
    endfunction

    function void check_row(logic [25:0] addr, logic [31:0] pixels, logic last);
      glyph_row_t e;
      rows_seen++;
      if (owed_rows.size() == 0) begin
        $error("row with nothing owed: row_address=%h row_pixels=%h last_row=%b",
               addr, pixels, last);
        errors++;
        return;
      end
      e = owed_rows.pop_front();
      if (addr !== e.addr) begin
        $error("row_address expected %h actual %h", e.addr, addr);
        errors++;
      end
      if (pixels !== e.pixels) begin
        $error("row_pixels expected %h actual %h", e.pixels, pixels);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_row expected %b actual %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [10:0] cell_column;
  logic [10:0] cell_row;
  logic [21:0] linear_position;
  logic [14:0] font_address;
  logic [7:0]  font_byte;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [7:0]  wr_data;
  logic        strobe;
  logic [25:0] row_address;
  logic [31:0] row_pixels;
  logic        last_row;

  glyph_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned geometries;
  int          burst_left;
  int          quiet_count;

  bitmap_glyph_row_renderer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .char_code      (char_code),
    .cell_column    (cell_column),
    .cell_row       (cell_row),
    .linear_position(linear_position),
    .font_address   (font_address),
    .font_byte      (font_byte),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .strobe         (strobe),
    .row_address    (row_address),
    .row_pixels     (row_pixels),
    .last_row       (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobed row is checked at the edge that
  // ends its cycle. The values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_row(row_address, row_pixels, last_row);
  end

  // The watchdog restarts on any accepted item, result or register write.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || wr_en) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= WATCHDOG_CYCLES) begin
        $display("Timeout: no progress for %0d cycles, %0d rows still owed",
                 WATCHDOG_CYCLES, sb.owed_rows.size());
        $display("FAIL bitmap_glyph_row_renderer_unit");
        $finish;
      end
    end
  end

  // Gap before the next item: mostly random, with occasional runs of
  // back-to-back items so that the block also sees start held high.
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Every field gets fresh random bits, including the ones the mode does not use.
  function automatic glyph_cmd_t random_cmd();
    glyph_cmd_t c;
    c.mode      = 2'($urandom);
    c.code      = 8'($urandom);
    c.column    = 11'($urandom);
    c.row       = 11'($urandom);
    c.position  = 22'($urandom);
    c.font_addr = 15'($urandom);
    c.font_data = 8'($urandom);
    return c;
  endfunction

  function automatic int unsigned pick_edge(int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Drives one item at a falling edge and holds it until the block takes it.
  // Start is left high on return; the next call either lowers it for a gap or
  // keeps it high with the next item's fields.
  task automatic send(glyph_cmd_t c);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start           = 1'b1;
    mode            = c.mode;
    char_code       = c.code;
    cell_column     = c.column;
    cell_row        = c.row;
    linear_position = c.position;
    font_address    = c.font_addr;
    font_byte       = c.font_data;
    do @(posedge clk); while (busy);
    sb.note_item(c);
    items_sent++;
  endtask

  task automatic load_byte(int unsigned addr, logic [7:0] data);
    glyph_cmd_t c;
    c           = random_cmd();
    c.mode      = MODE_LOAD;
    c.font_addr = 15'(addr);
    c.font_data = data;
    send(c);
  endtask

  task automatic render_at(logic [1:0] m, logic [7:0] code, int unsigned col,
                           int unsigned row, int unsigned pos);
    glyph_cmd_t c;
    c          = random_cmd();
    c.mode     = m;
    c.code     = code;
    c.column   = 11'(col);
    c.row      = 11'(row);
    c.position = 22'(pos);
    send(c);
  endtask

  // Writes every byte of one glyph under the current geometry, with black and
  // white bytes mixed in among random ones.
  task automatic load_glyph(logic [7:0] code);
    int unsigned n;
    logic [7:0]  data;
    n = sb.clamp_dim(sb.height_reg) * ((sb.clamp_dim(sb.width_reg) + 7) / 8);
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      load_byte(sb.glyph_byte_addr(code, k), data);
    end
  endtask

  // Renders a glyph in either mode, either on the screen (often at its edges)
  // or past it in column, row or linear position.
  task automatic render_random(logic [7:0] code, bit on_screen);
    int unsigned cols;
    int unsigned rows;
    int unsigned cx;
    int unsigned cy;
    logic [1:0]  m;
    cols = SCREEN_W / sb.clamp_dim(sb.width_reg);
    rows = SCREEN_H / sb.clamp_dim(sb.height_reg);
    m    = $urandom_range(0, 1) ? MODE_CELL : MODE_LINEAR;
    if (on_screen) begin
      cx = pick_edge(cols - 1);
      cy = pick_edge(rows - 1);
      render_at(m, code, cx, cy, cy * cols + cx);
    end else if (m == MODE_CELL) begin
      if ($urandom_range(0, 1)) render_at(m, code, $urandom_range(cols, 2047), $urandom, 0);
      else render_at(m, code, $urandom, $urandom_range(rows, 2047), 0);
    end else begin
      render_at(m, code, 0, 0, $urandom_range(cols * rows, 22'h3F_FFFF));
    end
  endtask

  // Lets the block drain before a register write: every owed row must arrive,
  // then a quiet spell covers loads and off-screen renders that end silently.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.owed_rows.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // One geometry setting: the raw register values are written as given, so
  // upper bits and out-of-range values reach the block, and then a mix of well
  // formed load-then-draw sequences, stray loads and ignored items follows.
  task automatic run_geometry(logic [7:0] w, logic [7:0] h, logic [7:0] stride,
                              int unsigned budget);
    int unsigned first;
    int unsigned pick;
    logic [7:0]  codes[4];
    logic [7:0]  code;
    settle();
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_BYTES_PER_GLYPH, stride);
    geometries++;
    codes[0] = 8'h00;
    codes[1] = 8'hFF;
    codes[2] = 8'($urandom);
    codes[3] = 8'($urandom);
    first = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_byte($urandom, 8'($urandom));
      end else if (pick < 11) begin
        render_at(MODE_IGNORED, 8'($urandom), $urandom, $urandom, $urandom);
      end else begin
        code = codes[$urandom_range(0, 3)];
        if (!sb.glyph_ready(code) || $urandom_range(0, 3) == 0) load_glyph(code);
        repeat ($urandom_range(1, 3)) render_random(code, $urandom_range(0, 99) < 85);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    mode            = MODE_LOAD;
    char_code       = '0;
    cell_column     = '0;
    cell_row        = '0;
    linear_position = '0;
    font_address    = '0;
    font_byte       = '0;
    wr_en           = 1'b0;
    wr_index        = REG_GLYPH_WIDTH;
    wr_data         = '0;
    items_sent      = 0;
    geometries      = 1;
    burst_left      = 0;
    quiet_count     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Under the reset geometry (8 by 16) row 67 is below the
    // screen, so nothing may come back; a wrong reset height would draw here.
    render_at(MODE_CELL, 8'h00, 0, 67, 0);

    // Keep the reset width of 8 and shrink glyphs to 2 rows of 1 byte, giving a
    // 240 by 540 cell screen.
    settle();
    write_reg(REG_GLYPH_HEIGHT, 8'd2);
    write_reg(REG_BYTES_PER_GLYPH, 8'd2);
    geometries++;
    load_byte(0, 8'hFF);
    load_byte(1, 8'h00);
    load_byte(510, 8'hA5);
    load_byte(511, 8'h80);
    load_byte(STORE_BYTES - 1, 8'hFF);
    render_at(MODE_CELL, 8'h00, 0, 0, 0);
    render_at(MODE_CELL, 8'hFF, 239, 539, 0);
    // Just past the right edge, just past the bottom, and both fields at their maximum.
    render_at(MODE_CELL, 8'hFF, 240, 0, 0);
    render_at(MODE_CELL, 8'hFF, 0, 540, 0);
    render_at(MODE_CELL, 8'hFF, 2047, 2047, 0);
    // Linear positions: first cell, last cell, one past it, and the largest value.
    render_at(MODE_LINEAR, 8'h00, 0, 0, 0);
    render_at(MODE_LINEAR, 8'hFF, 0, 0, 129599);
    render_at(MODE_LINEAR, 8'hFF, 0, 0, 129600);
    render_at(MODE_LINEAR, 8'h00, 0, 0, 22'h3F_FFFF);
    render_at(MODE_IGNORED, 8'($urandom), $urandom, $urandom, $urandom);

    // Glyph 254 at 129 bytes per glyph starts two bytes before the end of the
    // store, so its second row wraps around to addresses 0 and 1.
    settle();
    write_reg(REG_GLYPH_WIDTH, 8'd16);
    write_reg(REG_BYTES_PER_GLYPH, 8'd129);
    geometries++;
    load_byte(STORE_BYTES - 2, 8'h81);
    load_byte(STORE_BYTES - 1, 8'h7E);
    render_at(MODE_CELL, 8'hFE, 0, 0, 0);
    render_at(MODE_LINEAR, 8'hFE, 0, 0, 64799);

    // Random part over several geometries, the extremes among them: the default
    // 8 by 16 written back, the smallest glyph, full width, full height with
    // overlapping glyphs, all zero values, and oversized raw values that clamp
    // to 32 by 3 with the largest stride.
    run_geometry(8'(WIDTH_RST), 8'(HEIGHT_RST), BPG_RST, 45);
    run_geometry(8'd1, 8'd1, 8'd1, 40);
    run_geometry(8'd32, 8'd2, 8'd128, 40);
    run_geometry(8'd2, 8'd32, 8'd1, 40);
    run_geometry(8'd0, 8'd0, 8'd0, 30);
    run_geometry(8'hFF, 8'hC3, 8'hFF, 35);
    repeat (3) begin
      run_geometry(8'($urandom_range(1, 16)), 8'($urandom_range(1, 12)), 8'($urandom), 40);
    end

    settle();
    if (sb.owed_rows.size() != 0) begin
      $error("%0d rows never arrived", sb.owed_rows.size());
      sb.errors++;
    end
    $display("Sent %0d items over %0d geometries: %0d font loads, %0d glyphs drawn,",
             items_sent, geometries, sb.loads, sb.drawn_glyphs);
    $display("%0d items with no rows (off screen or ignored), %0d rows checked.",
             sb.silent_items, sb.rows_seen);
    if (sb.errors == 0) begin
      $display("PASS bitmap_glyph_row_renderer_unit");
    end else begin
      $display("FAIL bitmap_glyph_row_renderer_unit");
    end
    $finish;
  end

endmodule
